// ----- hw/rtl/tmba_pkg.sv -----
package tmba_pkg;

  // One 64-bit running sum.
  typedef logic [63:0] sum_t;

  // One memory entry: both sums of one bin and one side.
  typedef struct packed {
    sum_t amount;
    sum_t volume;
  } entry_t;

  // Session boundaries as minutes of the day.
  localparam logic [11:0] MORNING_OPEN   = 12'd570;
  localparam logic [11:0] MORNING_END    = 12'd750;
  localparam logic [11:0] AFTERNOON_OPEN = 12'd780;

  // Bins per session and the last offset inside a session.
  localparam logic [7:0] SESSION_BINS = 8'd121;
  localparam logic [7:0] SESSION_LAST = 8'd120;

  // Division by 100 as a multiply by a rounded-up reciprocal and a shift.
  // The wide form covers any 18-bit hhmmss, the narrow one any 12-bit hhmm.
  localparam logic [19:0] DIV100_WIDE_MUL   = 20'd671089;
  localparam int          DIV100_WIDE_SHIFT = 26;
  localparam logic [12:0] DIV100_NARROW_MUL   = 13'd5243;
  localparam int          DIV100_NARROW_SHIFT = 19;

  // Minutes dropped per hour when hh*100+mm becomes hh*60+mm.
  localparam logic [11:0] HOUR_GAP = 12'd40;

endpackage

// ----- hw/rtl/tmba_if.sv -----
// Request channel: a trade to add or a bin to read and clear.
interface tmba_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [17:0] trade_time;
  logic [23:0] price_hundredths;
  logic [30:0] trade_volume;
  logic        is_buy;
  logic [7:0]  bin_select;

  modport source(
    output valid, req_type, trade_time, price_hundredths, trade_volume, is_buy, bin_select,
    input  ready
  );
  modport sink(
    input  valid, req_type, trade_time, price_hundredths, trade_volume, is_buy, bin_select,
    output ready
  );
endinterface

// Response channel: the four sums of one bin.
interface tmba_rsp_if;
  import tmba_pkg::*;

  logic valid;
  logic ready;
  sum_t sell_volume_sum;
  sum_t sell_amount_sum;
  sum_t buy_volume_sum;
  sum_t buy_amount_sum;

  modport source(
    output valid, sell_volume_sum, sell_amount_sum, buy_volume_sum, buy_amount_sum,
    input  ready
  );
  modport sink(
    input  valid, sell_volume_sum, sell_amount_sum, buy_volume_sum, buy_amount_sum,
    output ready
  );
endinterface

// ----- hw/rtl/trade_minute_bin_accumulator_core.sv -----
// Channel | Dir | Accepted when         | Payload
// req     | in  | valid && ready        | req_type, trade_time, price_hundredths,
//         |     |                       | trade_volume, is_buy, bin_select
// rsp     | out | valid && ready        | sell/buy volume and amount sums
//
// One item at a time. A trade passes through accept, the time-to-bin pipeline (two
// reciprocal multiplies and the clamp), then a read-modify-write of one memory entry.
// A read request reads its row at accept, then waits for the response register.
// After reset a clearing pass writes zero to all NUM_BINS rows, one row a cycle, and
// req.ready stays low until the pass is done.
// A stalled response holds its register; a trade may still be taken meanwhile.
module trade_minute_bin_accumulator_core #(
  parameter int NUM_BINS = 242
) (
  input  logic        clk,
  input  logic        rst,
  tmba_req_if.sink    req,
  tmba_rsp_if.source  rsp
);
  import tmba_pkg::*;

  localparam int ADDR_W = $clog2(NUM_BINS);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MAP  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] bin_r;
  logic [ADDR_W-1:0] sel_addr_r;
  logic              sel_ok_r;
  logic              is_buy_r;
  logic [30:0]       vol_r;
  logic [23:0]       price_r;
  logic [54:0]       amount_r;

  logic              rsp_valid;
  entry_t            rsp_sell;
  entry_t            rsp_buy;

  entry_t            sell_mem [NUM_BINS];
  entry_t            buy_mem  [NUM_BINS];
  entry_t            sell_rd;
  entry_t            buy_rd;
  entry_t            cur;
  entry_t            upd;
  entry_t            sell_wdata;
  entry_t            buy_wdata;
  logic              sell_we;
  logic              buy_we;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;

  logic              req_fire;
  logic              out_free;
  logic              map_done;
  logic [ADDR_W-1:0] map_bin;

  function automatic sum_t sat_add(sum_t a, sum_t b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign out_free  = !rsp_valid || rsp.ready;

  tmba_bin_map #(
    .NUM_BINS(NUM_BINS)
  ) u_bin_map (
    .clk        (clk),
    .rst        (rst),
    .start      (req_fire && !req.req_type),
    .trade_time (req.trade_time),
    .done       (map_done),
    .bin        (map_bin)
  );

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR: begin
        if (clr_addr == ADDR_W'(NUM_BINS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_fire) begin
          state_next = req.req_type ? S_OUT : S_MAP;
        end
      end
      S_MAP: begin
        if (map_done) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        state_next = S_IDLE;
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // Item fields held while the item is at work.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      is_buy_r   <= req.is_buy;
      vol_r      <= req.trade_volume;
      price_r    <= req.price_hundredths;
      sel_addr_r <= ADDR_W'(req.bin_select);
      sel_ok_r   <= (32'(req.bin_select) < NUM_BINS);
    end
    if (state == S_MAP) begin
      amount_r <= 55'(price_r) * 55'(vol_r);
    end
    if (state == S_MAP && map_done) begin
      bin_r <= map_bin;
    end
  end

  // Memory port control. Reads and writes fall in different states, so the same
  // row is never read and written in one cycle.
  assign rd_en   = (req_fire && req.req_type) || (state == S_MAP && map_done);
  assign rd_addr = (state == S_IDLE) ? ADDR_W'(req.bin_select) : map_bin;

  always_comb begin
    cur        = is_buy_r ? buy_rd : sell_rd;
    upd.volume = sat_add(cur.volume, 64'(vol_r));
    upd.amount = sat_add(cur.amount, 64'(amount_r));
    sell_we    = 1'b0;
    buy_we     = 1'b0;
    sell_wdata = '0;
    buy_wdata  = '0;
    wr_addr    = sel_addr_r;
    unique case (state)
      S_CLR: begin
        sell_we = 1'b1;
        buy_we  = 1'b1;
        wr_addr = clr_addr;
      end
      S_ADD: begin
        sell_we    = !is_buy_r;
        buy_we     = is_buy_r;
        sell_wdata = upd;
        buy_wdata  = upd;
        wr_addr    = bin_r;
      end
      S_OUT: begin
        sell_we = out_free && sel_ok_r;
        buy_we  = out_free && sel_ok_r;
      end
      default: begin
      end
    endcase
  end

  // Two row stores, one per side, each with a registered read.
  always_ff @(posedge clk) begin
    if (sell_we) begin
      sell_mem[wr_addr] <= sell_wdata;
    end
    if (buy_we) begin
      buy_mem[wr_addr] <= buy_wdata;
    end
    if (rd_en) begin
      sell_rd <= sell_mem[rd_addr];
      buy_rd  <= buy_mem[rd_addr];
    end
  end

  // Response register; an out-of-range bin answers with zeros.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      rsp_sell <= sel_ok_r ? sell_rd : '0;
      rsp_buy  <= sel_ok_r ? buy_rd : '0;
    end
  end

  assign rsp.valid           = rsp_valid;
  assign rsp.sell_volume_sum = rsp_sell.volume;
  assign rsp.sell_amount_sum = rsp_sell.amount;
  assign rsp.buy_volume_sum  = rsp_buy.volume;
  assign rsp.buy_amount_sum  = rsp_buy.amount;

endmodule

// ----- hw/rtl/tmba_bin_map.sv -----
// Three-stage pipeline from a decimal hhmmss time to a bin index.
module tmba_bin_map #(
  parameter int NUM_BINS = 242
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [17:0]                   trade_time,
  output logic                          done,
  output logic [$clog2(NUM_BINS)-1:0]   bin
);
  import tmba_pkg::*;

  localparam int ADDR_W = $clog2(NUM_BINS);

  logic        v1;
  logic        v2;
  logic [11:0] hhmm1;
  logic [11:0] hhmm2;
  logic [5:0]  hh2;
  logic [37:0] wide_prod;
  logic [24:0] narrow_prod;
  logic [11:0] minute;
  logic [11:0] offset;
  logic [7:0]  bin_raw;

  // Stage products: hhmm = hhmmss / 100, hh = hhmm / 100.
  assign wide_prod   = 38'(trade_time) * 38'(DIV100_WIDE_MUL);
  assign narrow_prod = 25'(hhmm1) * 25'(DIV100_NARROW_MUL);

  // Minute of the day and the clamped session offset.
  always_comb begin
    minute = hhmm2 - 12'(hh2) * HOUR_GAP;
    offset = '0;
    if (minute < MORNING_END) begin
      if (minute > MORNING_OPEN) begin
        offset = minute - MORNING_OPEN;
      end
    end else begin
      if (minute > AFTERNOON_OPEN) begin
        offset = minute - AFTERNOON_OPEN;
      end
    end
    if (offset > 12'(SESSION_LAST)) begin
      offset = 12'(SESSION_LAST);
    end
    if (minute < MORNING_END) begin
      bin_raw = offset[7:0];
    end else begin
      bin_raw = SESSION_BINS + offset[7:0];
    end
  end

  // Valid bits of the stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      done <= v2;
    end
  end

  // Stage data; a bin beyond the store goes to the last bin.
  always_ff @(posedge clk) begin
    hhmm1 <= wide_prod[DIV100_WIDE_SHIFT +: 12];
    hhmm2 <= hhmm1;
    hh2   <= narrow_prod[DIV100_NARROW_SHIFT +: 6];
    if (32'(bin_raw) > NUM_BINS - 1) begin
      bin <= ADDR_W'(NUM_BINS - 1);
    end else begin
      bin <= ADDR_W'(bin_raw);
    end
  end

endmodule

// ----- hw/rtl/tmba_checker.sv -----
// Port-level checks of the accumulator.
module tmba_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        req_type,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [63:0] sell_volume_sum,
  input logic [63:0] sell_amount_sum,
  input logic [63:0] buy_volume_sum,
  input logic [63:0] buy_amount_sum
);

  logic       req_read;
  logic       rsp_fire;
  logic [1:0] pending;

  assign req_read = req_valid && req_ready && req_type;
  assign rsp_fire = rsp_valid && rsp_ready;

  // Read items accepted whose responses have not yet gone out.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (req_read && !rsp_fire) begin
      pending <= pending + 1'b1;
    end else if (rsp_fire && !req_read) begin
      pending <= pending - 1'b1;
    end
  end

  // The clearing pass blocks requests and no response exists right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !req_ready && !rsp_valid)
    else $error("request taken or response shown right after reset");

  // Every response answers an earlier read request.
  a_rsp_has_req: assert property (@(posedge clk) disable iff (rst)
    rsp_fire |-> pending != 2'd0)
    else $error("response without a read request");

  // At most one response waits while one more read is in flight.
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("too many read requests outstanding");

  // A stalled response stays valid and keeps its sums.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(sell_volume_sum)
      && $stable(sell_amount_sum) && $stable(buy_volume_sum) && $stable(buy_amount_sum))
    else $error("stalled response changed");

endmodule

bind trade_minute_bin_accumulator_core tmba_checker u_tmba_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .req_type        (req.req_type),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .sell_volume_sum (rsp.sell_volume_sum),
  .sell_amount_sum (rsp.sell_amount_sum),
  .buy_volume_sum  (rsp.buy_volume_sum),
  .buy_amount_sum  (rsp.buy_amount_sum)
);
